>>> rtl/hss_pkg.sv
// Shared types and constants of the five-point heat stencil step.
// Used by heat_stencil_step, hss_update and the testbench; depends on nothing else.
package hss_pkg;

   // Default sizes handed to the top level parameters
   localparam int DEF_MAX_COLS  = 1024;
   localparam int DEF_FRAC_BITS = 16;

   // Fixed field widths
   localparam int TEMP_W     = 32;
   localparam int COL_OUT_W  = 10;
   localparam int ROW_W      = 16;
   localparam int GCOLS_W    = 11;
   localparam int COEFF_W    = 16;
   localparam int GAIN_W     = 18;
   localparam int SIDE_W     = 50;
   localparam int ACC_W      = 64;
   localparam int ROW_WORD_W = 2 * TEMP_W;

   // Configuration port
   localparam int CSR_AW = 6;
   localparam int CSR_DW = 64;
   localparam int CSR_IDX_LSB = 3;

   // Register reset values
   localparam logic [GCOLS_W-1:0] GRID_COLS_RST = GCOLS_W'(16);
   localparam logic [ROW_W-1:0]   GRID_ROWS_RST = ROW_W'(16);

   // Result queue
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_AW    = 3;
   localparam int FIFO_CW    = 4;

   // Neighbor directions; the boundary registers follow the same order
   localparam int DIR_WEST  = 0;
   localparam int DIR_EAST  = 1;
   localparam int DIR_SOUTH = 2;
   localparam int DIR_NORTH = 3;
   localparam int NUM_DIRS  = 4;

   typedef enum logic [2:0] {
      REG_GRID_COLS  = 3'd0,
      REG_GRID_ROWS  = 3'd1,
      REG_COEFF      = 3'd2,
      REG_SIDE_LEFT  = 3'd3,
      REG_SIDE_RIGHT = 3'd4,
      REG_SIDE_BOT   = 3'd5,
      REG_SIDE_TOP   = 3'd6
   } csr_reg_type;

   typedef struct packed {
      logic [GAIN_W-1:0] gain;
      logic [TEMP_W-1:0] bias;
   } side_type;

   typedef struct packed {
      logic [COEFF_W-1:0]                coeff;
      side_type [NUM_DIRS-1:0]           side;
   } cfg_type;

   // One cell update: center value, neighbors and which of them exist
   typedef struct packed {
      logic [TEMP_W-1:0]                 t;
      logic [NUM_DIRS-1:0][TEMP_W-1:0]   nb;
      logic [NUM_DIRS-1:0]               has;
      logic [COL_OUT_W-1:0]              col;
      logic [ROW_W-1:0]                  row;
      logic                              last;
   } job_type;

   typedef struct packed {
      logic [TEMP_W-1:0]    new_temperature;
      logic [COL_OUT_W-1:0] col;
      logic [ROW_W-1:0]     row;
      logic                 last;
   } rsp_type;

endpackage

>>> rtl/hss_ram.sv
// Generic synchronous RAM: one write port, two registered read ports.
// Self-contained; no package needed.
module hss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr_a,
   output logic [WIDTH-1:0] rd_data_a,
   input  logic [AW-1:0]    rd_addr_b,
   output logic [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   // Write, and register both reads (old data on a same-address write)
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

>>> rtl/hss_update.sv
// Cell update pipeline: four side terms, sum, rounding shift, saturation.
// Depends on hss_pkg for job, configuration and result types.
module hss_update #(
   parameter int FRAC_BITS = hss_pkg::DEF_FRAC_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  hss_pkg::job_type  in_job,
   input  hss_pkg::cfg_type  cfg,
   output logic              out_valid,
   output hss_pkg::rsp_type  out_rsp,
   output logic [1:0]        inflight
);
   import hss_pkg::*;

   localparam int MA_W = GAIN_W + 1;
   localparam int MB_W = TEMP_W + 1;
   localparam int P_W  = MA_W + MB_W;
   localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (FRAC_BITS - 1);

   logic                          v1_ff, v2_ff, v3_ff;
   job_type                       j1_ff, j2_ff, j3_ff;
   logic signed [P_W-1:0]         p_ff [NUM_DIRS];
   logic signed [P_W-1:0]         p_in [NUM_DIRS];
   logic signed [ACC_W-1:0]       s01_ff, s23_ff, s01_in, s23_in;
   logic signed [ACC_W-1:0]       acc_ff, acc_in;
   logic signed [ACC_W-1:0]       sum_val;

   // Stage 1: one product per side (neighbor difference or boundary gain)
   always_comb begin
      logic signed [MA_W-1:0] ma;
      logic signed [MB_W-1:0] mb;
      for (int k = 0; k < NUM_DIRS; k++) begin
         if (in_job.has[k]) begin
            ma = $signed({3'b000, cfg.coeff});
            mb = $signed({in_job.nb[k][TEMP_W-1], in_job.nb[k]})
                 - $signed({in_job.t[TEMP_W-1], in_job.t});
         end else begin
            ma = $signed({1'b0, cfg.side[k].gain});
            mb = $signed({in_job.t[TEMP_W-1], in_job.t});
         end
         p_in[k] = ma * mb;
      end
   end

   // Stage 2: form the side terms and add them in pairs
   always_comb begin
      logic signed [ACC_W-1:0] term [NUM_DIRS];
      logic signed [ACC_W-1:0] bias_sc;
      for (int k = 0; k < NUM_DIRS; k++) begin
         bias_sc = ACC_W'($signed(cfg.side[k].bias)) <<< FRAC_BITS;
         if (j1_ff.has[k]) begin
            term[k] = ACC_W'(p_ff[k]);
         end else begin
            term[k] = bias_sc - ACC_W'(p_ff[k]);
         end
      end
      s01_in = term[DIR_WEST] + term[DIR_EAST];
      s23_in = term[DIR_SOUTH] + term[DIR_NORTH];
   end

   // Stage 3: total change with the rounding offset
   assign acc_in = s01_ff + s23_ff + HALF;

   // Control: advance the valid bits every cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // Payload stages
   always_ff @(posedge clock) begin
      j1_ff <= in_job;
      for (int k = 0; k < NUM_DIRS; k++) begin
         p_ff[k] <= p_in[k];
      end
      j2_ff  <= j1_ff;
      s01_ff <= s01_in;
      s23_ff <= s23_in;
      j3_ff  <= j2_ff;
      acc_ff <= acc_in;
   end

   // Output: shift down, add the center value, saturate to 32 bits
   assign sum_val = ACC_W'($signed(j3_ff.t)) + (acc_ff >>> FRAC_BITS);

   always_comb begin
      out_rsp.col  = j3_ff.col;
      out_rsp.row  = j3_ff.row;
      out_rsp.last = j3_ff.last;
      if (!sum_val[ACC_W-1] && (sum_val[ACC_W-2:TEMP_W-1] != '0)) begin
         out_rsp.new_temperature = {1'b0, {(TEMP_W-1){1'b1}}};
      end else if (sum_val[ACC_W-1] && (sum_val[ACC_W-2:TEMP_W-1] != '1)) begin
         out_rsp.new_temperature = {1'b1, {(TEMP_W-1){1'b0}}};
      end else begin
         out_rsp.new_temperature = sum_val[TEMP_W-1:0];
      end
   end

   assign out_valid = v3_ff;
   assign inflight  = 2'(v1_ff) + 2'(v2_ff) + 2'(v3_ff);

endmodule

>>> rtl/heat_stencil_step.sv
// Five-point explicit heat step over a grid streamed in raster order.
// Top level; uses hss_pkg, hss_ram (row store) and hss_update (arithmetic).
//
// Temperatures enter one word per cycle, bottom row first. Each word of row r
// releases the updated cell (r-1, c); on the last row it also releases (r, c-1)
// past column 0 and, at the last column, (r, c), so the last row delivers two
// results per input (three at its final column). One result leaves per cycle,
// so on the last row the input waits until all results of the last word have
// issued; elsewhere it takes a word every cycle while credit remains. The two
// previous rows sit in one MAX_COLS-deep RAM word pair {older, middle}, read
// at the input edge and written back as the word leaves the read stage. Results
// pass the read, issue and update stages into an 8-word queue, so the input
// keeps running while the output is stalled until the queue credit runs out.
// Geometry writes restart the grid at row 0, column 0. Store entries carry no
// reset; in normal flow every entry is written before it is read.
module heat_stencil_step #(
   parameter int MAX_COLS  = hss_pkg::DEF_MAX_COLS,
   parameter int FRAC_BITS = hss_pkg::DEF_FRAC_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   // input channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [hss_pkg::TEMP_W-1:0]    req_temperature,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [hss_pkg::TEMP_W-1:0]    rsp_new_temperature,
   output logic [hss_pkg::COL_OUT_W-1:0] rsp_col,
   output logic [hss_pkg::ROW_W-1:0]     rsp_row,
   output logic                          rsp_last_of_run,
   // configuration port
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [hss_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [hss_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [hss_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                          csr_pready
);
   import hss_pkg::*;

   localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

   // Configuration registers
   logic [GCOLS_W-1:0]               grid_cols_ff;
   logic [ROW_W-1:0]                 grid_rows_ff;
   logic [COEFF_W-1:0]               coeff_ff;
   logic [NUM_DIRS-1:0][SIDE_W-1:0]  side_ff;
   logic                             csr_wr;
   csr_reg_type                      csr_idx;
   cfg_type                          cfg;

   // Geometry and position
   logic [COL_W-1:0]                 cols_m1;
   logic [ROW_W-1:0]                 rows_m1;
   logic [COL_W-1:0]                 col_ff;
   logic [ROW_W-1:0]                 row_ff;
   logic                             req_acc;
   logic                             at_last_col;

   // Input history
   logic [TEMP_W-1:0]                held_top_ff;
   logic [TEMP_W-1:0]                two_back_ff;
   logic [TEMP_W-1:0]                held_west_ff;

   // Read stage
   logic                             a_valid_ff;
   logic [COL_W-1:0]                 a_col_ff;
   logic [ROW_W-1:0]                 a_row_ff;
   logic [TEMP_W-1:0]                a_temp_ff;
   logic [TEMP_W-1:0]                a_prev_ff;
   logic [TEMP_W-1:0]                a_prev2_ff;
   logic                             a_first_row_ff;
   logic                             a_last_row_ff;
   logic                             a_last_col_ff;
   logic                             a_fwd_a_ff, a_fwd_b_ff;
   logic [ROW_WORD_W-1:0]            a_fwd_word_ff;
   logic                             a_adv;

   // Row store
   logic [COL_W-1:0]                 rd_addr_b;
   logic [ROW_WORD_W-1:0]            rd_word_a, rd_word_b;
   logic [ROW_WORD_W-1:0]            word_a, word_b;
   logic                             st_wr_en;
   logic [ROW_WORD_W-1:0]            st_wr_data;
   logic [TEMP_W-1:0]                self_val, south_val, east_val;

   // Job bundle
   job_type                          new_job [3];
   logic [2:0]                       new_mask;
   job_type                          b_job_ff [3];
   logic [2:0]                       b_mask_ff;
   logic [2:0]                       b_rem;
   job_type                          issue_job;
   logic                             b_issue;
   logic                             credit_ok;

   // Arithmetic and result queue
   logic                             upd_valid;
   rsp_type                          upd_rsp;
   logic [1:0]                       upd_inflight;
   rsp_type                          fifo_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]               wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CW-1:0]               fifo_cnt_ff;
   logic                             fifo_pop;
   rsp_type                          head;

   // ---------------- configuration ----------------
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_reg_type'(csr_paddr[CSR_AW-1:CSR_IDX_LSB]);
   assign csr_pready = 1'b1;

   // Write registers
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_cols_ff <= GRID_COLS_RST;
         grid_rows_ff <= GRID_ROWS_RST;
         coeff_ff     <= '0;
         side_ff      <= '0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_GRID_COLS:  grid_cols_ff <= csr_pwdata[GCOLS_W-1:0];
            REG_GRID_ROWS:  grid_rows_ff <= csr_pwdata[ROW_W-1:0];
            REG_COEFF:      coeff_ff     <= csr_pwdata[COEFF_W-1:0];
            REG_SIDE_LEFT:  side_ff[DIR_WEST]  <= csr_pwdata[SIDE_W-1:0];
            REG_SIDE_RIGHT: side_ff[DIR_EAST]  <= csr_pwdata[SIDE_W-1:0];
            REG_SIDE_BOT:   side_ff[DIR_SOUTH] <= csr_pwdata[SIDE_W-1:0];
            REG_SIDE_TOP:   side_ff[DIR_NORTH] <= csr_pwdata[SIDE_W-1:0];
            default: ;
         endcase
      end
   end

   // Read back
   always_comb begin
      unique case (csr_idx)
         REG_GRID_COLS:  csr_prdata = CSR_DW'(grid_cols_ff);
         REG_GRID_ROWS:  csr_prdata = CSR_DW'(grid_rows_ff);
         REG_COEFF:      csr_prdata = CSR_DW'(coeff_ff);
         REG_SIDE_LEFT:  csr_prdata = CSR_DW'(side_ff[DIR_WEST]);
         REG_SIDE_RIGHT: csr_prdata = CSR_DW'(side_ff[DIR_EAST]);
         REG_SIDE_BOT:   csr_prdata = CSR_DW'(side_ff[DIR_SOUTH]);
         REG_SIDE_TOP:   csr_prdata = CSR_DW'(side_ff[DIR_NORTH]);
         default:        csr_prdata = '0;
      endcase
   end

   // Split side registers into gain and bias
   always_comb begin
      cfg.coeff = coeff_ff;
      for (int k = 0; k < NUM_DIRS; k++) begin
         cfg.side[k].gain = side_ff[k][SIDE_W-1:TEMP_W];
         cfg.side[k].bias = side_ff[k][TEMP_W-1:0];
      end
   end

   // Clamp geometry to the supported range
   always_comb begin
      int unsigned gc;
      gc = 32'(grid_cols_ff);
      if (gc < 2) begin
         gc = 2;
      end
      if (gc > MAX_COLS) begin
         gc = MAX_COLS;
      end
      cols_m1 = COL_W'(gc - 1);
      rows_m1 = (grid_rows_ff < ROW_W'(2)) ? ROW_W'(1) : grid_rows_ff - ROW_W'(1);
   end

   // ---------------- input and position ----------------
   assign req_acc     = req_valid && !req_stall;
   assign req_stall   = a_valid_ff && !a_adv;
   assign at_last_col = (col_ff == cols_m1);

   // Advance the raster position; a geometry write restarts the grid
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (csr_wr && (csr_idx == REG_GRID_COLS || csr_idx == REG_GRID_ROWS)) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_acc) begin
         if (at_last_col) begin
            col_ff <= '0;
            row_ff <= (row_ff == rows_m1) ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_ff <= col_ff + COL_W'(1);
         end
      end
   end

   // Keep the last two input words
   always_ff @(posedge clock) begin
      if (reset) begin
         held_top_ff <= '0;
         two_back_ff <= '0;
      end else if (req_acc) begin
         held_top_ff <= req_temperature;
         two_back_ff <= held_top_ff;
      end
   end

   // ---------------- read stage ----------------
   assign rd_addr_b = at_last_col ? '0 : col_ff + COL_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (req_acc) begin
         a_valid_ff <= 1'b1;
      end else if (a_adv) begin
         a_valid_ff <= 1'b0;
      end
   end

   // Capture the word, its place, and any same-edge store write
   always_ff @(posedge clock) begin
      if (req_acc) begin
         a_col_ff       <= col_ff;
         a_row_ff       <= row_ff;
         a_temp_ff      <= req_temperature;
         a_prev_ff      <= held_top_ff;
         a_prev2_ff     <= two_back_ff;
         a_first_row_ff <= (row_ff == '0);
         a_last_row_ff  <= (row_ff == rows_m1);
         a_last_col_ff  <= at_last_col;
         a_fwd_a_ff     <= st_wr_en && (a_col_ff == col_ff);
         a_fwd_b_ff     <= st_wr_en && (a_col_ff == rd_addr_b);
         a_fwd_word_ff  <= st_wr_data;
      end
   end

   hss_ram #(
      .WIDTH (ROW_WORD_W),
      .DEPTH (MAX_COLS)
   ) u_row_store (
      .clock     (clock),
      .wr_en     (st_wr_en),
      .wr_addr   (a_col_ff),
      .wr_data   (st_wr_data),
      .rd_en     (req_acc),
      .rd_addr_a (col_ff),
      .rd_data_a (rd_word_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rd_word_b)
   );

   assign word_a    = a_fwd_a_ff ? a_fwd_word_ff : rd_word_a;
   assign word_b    = a_fwd_b_ff ? a_fwd_word_ff : rd_word_b;
   assign self_val  = word_a[TEMP_W-1:0];
   assign south_val = word_a[ROW_WORD_W-1:TEMP_W];
   assign east_val  = word_b[TEMP_W-1:0];

   // Write back {older <- middle, middle <- input} as the word leaves
   assign st_wr_en   = a_valid_ff && a_adv;
   assign st_wr_data = {self_val, a_temp_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         held_west_ff <= '0;
      end else if (st_wr_en && !a_first_row_ff) begin
         held_west_ff <= self_val;
      end
   end

   // Build up to three cell updates for this word
   always_comb begin
      logic [31:0] cw;
      logic [31:0] cw_m1;
      cw    = 32'(a_col_ff);
      cw_m1 = cw - 32'd1;

      // cell below the input
      new_job[0].t                = self_val;
      new_job[0].nb[DIR_WEST]     = held_west_ff;
      new_job[0].nb[DIR_EAST]     = east_val;
      new_job[0].nb[DIR_SOUTH]    = south_val;
      new_job[0].nb[DIR_NORTH]    = a_temp_ff;
      new_job[0].has[DIR_WEST]    = (a_col_ff != '0);
      new_job[0].has[DIR_EAST]    = !a_last_col_ff;
      new_job[0].has[DIR_SOUTH]   = (a_row_ff > ROW_W'(1));
      new_job[0].has[DIR_NORTH]   = 1'b1;
      new_job[0].col              = cw[COL_OUT_W-1:0];
      new_job[0].row              = a_row_ff - ROW_W'(1);
      new_job[0].last             = 1'b0;

      // top row: cell to the west of the input
      new_job[1].t                = a_prev_ff;
      new_job[1].nb[DIR_WEST]     = a_prev2_ff;
      new_job[1].nb[DIR_EAST]     = a_temp_ff;
      new_job[1].nb[DIR_SOUTH]    = held_west_ff;
      new_job[1].nb[DIR_NORTH]    = '0;
      new_job[1].has[DIR_WEST]    = (a_col_ff > COL_W'(1));
      new_job[1].has[DIR_EAST]    = 1'b1;
      new_job[1].has[DIR_SOUTH]   = 1'b1;
      new_job[1].has[DIR_NORTH]   = 1'b0;
      new_job[1].col              = cw_m1[COL_OUT_W-1:0];
      new_job[1].row              = a_row_ff;
      new_job[1].last             = 1'b0;

      // top row, last column: the input cell itself
      new_job[2].t                = a_temp_ff;
      new_job[2].nb[DIR_WEST]     = a_prev_ff;
      new_job[2].nb[DIR_EAST]     = '0;
      new_job[2].nb[DIR_SOUTH]    = self_val;
      new_job[2].nb[DIR_NORTH]    = '0;
      new_job[2].has[DIR_WEST]    = 1'b1;
      new_job[2].has[DIR_EAST]    = 1'b0;
      new_job[2].has[DIR_SOUTH]   = 1'b1;
      new_job[2].has[DIR_NORTH]   = 1'b0;
      new_job[2].col              = cw[COL_OUT_W-1:0];
      new_job[2].row              = a_row_ff;
      new_job[2].last             = 1'b0;

      new_mask[0] = !a_first_row_ff;
      new_mask[1] = a_last_row_ff && (a_col_ff != '0);
      new_mask[2] = a_last_row_ff && a_last_col_ff;
   end

   // ---------------- issue ----------------
   assign credit_ok = (5'(upd_inflight) + 5'(fifo_cnt_ff)) < 5'(FIFO_DEPTH);
   assign b_issue   = (b_mask_ff != '0) && credit_ok;
   assign a_adv     = (b_mask_ff == '0) || (b_issue && (b_rem == '0));

   // Pick the oldest pending update; mark the final one of the word
   always_comb begin
      priority if (b_mask_ff[0]) begin
         issue_job = b_job_ff[0];
         b_rem     = b_mask_ff & 3'b110;
      end else if (b_mask_ff[1]) begin
         issue_job = b_job_ff[1];
         b_rem     = b_mask_ff & 3'b100;
      end else begin
         issue_job = b_job_ff[2];
         b_rem     = 3'b000;
      end
      issue_job.last = (b_rem == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_mask_ff <= '0;
      end else if (a_valid_ff && a_adv) begin
         b_mask_ff <= new_mask;
      end else if (b_issue) begin
         b_mask_ff <= b_rem;
      end
   end

   always_ff @(posedge clock) begin
      if (a_valid_ff && a_adv) begin
         for (int k = 0; k < 3; k++) begin
            b_job_ff[k] <= new_job[k];
         end
      end
   end

   hss_update #(
      .FRAC_BITS (FRAC_BITS)
   ) u_update (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (b_issue),
      .in_job    (issue_job),
      .cfg       (cfg),
      .out_valid (upd_valid),
      .out_rsp   (upd_rsp),
      .inflight  (upd_inflight)
   );

   // ---------------- result queue ----------------
   assign fifo_pop = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
      end else begin
         if (upd_valid) begin
            wr_ptr_ff <= wr_ptr_ff + FIFO_AW'(1);
         end
         if (fifo_pop) begin
            rd_ptr_ff <= rd_ptr_ff + FIFO_AW'(1);
         end
         fifo_cnt_ff <= fifo_cnt_ff + FIFO_CW'(upd_valid) - FIFO_CW'(fifo_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (upd_valid) begin
         fifo_ff[wr_ptr_ff] <= upd_rsp;
      end
   end

   assign head                = fifo_ff[rd_ptr_ff];
   assign rsp_valid           = (fifo_cnt_ff != '0);
   assign rsp_new_temperature = head.new_temperature;
   assign rsp_col             = head.col;
   assign rsp_row             = head.row;
   assign rsp_last_of_run     = head.last;

   // ---------------- assertions ----------------
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      (5'(upd_inflight) + 5'(fifo_cnt_ff)) <= 5'(FIFO_DEPTH))
      else $error("result queue credit exceeded");

   a_read_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && !a_adv) |=> (a_valid_ff && $stable(a_col_ff) && $stable(a_temp_ff)))
      else $error("read stage lost a word while blocked");

   a_drain_last: assert property (@(posedge clock) disable iff (reset)
      (fifo_cnt_ff == FIFO_CW'(1) && fifo_pop && !upd_valid) |=> !rsp_valid)
      else $error("result queue count out of step");

endmodule

>>> dv/tb.sv
// Testbench for heat_stencil_step: streams grid temperatures, predicts each next-step cell.
// Depends on rtl/hss_pkg.sv and the heat_stencil_step RTL only.
`timescale 1ns / 100ps

module tb;
   import hss_pkg::*;

   localparam int NCOLS = 1024;
   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [TEMP_W-1:0] req_temperature = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [TEMP_W-1:0] rsp_new_temperature;
   logic [COL_OUT_W-1:0] rsp_col;
   logic [ROW_W-1:0] rsp_row;
   logic rsp_last_of_run;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic csr_pready;

   heat_stencil_step DUT (.*);

   // Mirror of the block's registers and state
   logic [GCOLS_W-1:0] m_cols = GRID_COLS_RST;
   logic [ROW_W-1:0] m_rows = GRID_ROWS_RST;
   logic [COEFF_W-1:0] m_coeff = '0;
   logic [SIDE_W-1:0] m_side [NUM_DIRS] = '{default: '0};
   int m_older [NCOLS] = '{default: 0};
   int m_middle [NCOLS] = '{default: 0};
   int unsigned m_col = 0, m_row = 0;
   int m_west = 0, m_top = 0;

   rsp_type pending_cells [$];
   int errors = 0, words_sent = 0, cells_checked = 0;
   int idle_pct = 0, stall_pct = 0;
   longint cycles = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Abort on hang
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d cells outstanding", cycles,
                  pending_cells.size());
         $display("FAIL heat_stencil_step");
         $finish;
      end
   end

   task automatic report(input string what);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, what);
   endtask

   function automatic longint side_term(input int dir, input longint t);
      longint gain, bias;
      gain = longint'(m_side[dir][49:32]);
      bias = longint'(int'(m_side[dir][31:0]));
      return bias * 65536 - gain * t;
   endfunction

   // One explicit step of a cell; a missing neighbor uses its side's boundary term
   function automatic logic [TEMP_W-1:0] next_temp(input longint t, input logic [3:0] has,
                                                   input longint w, input longint e,
                                                   input longint s, input longint n);
      longint nb [NUM_DIRS];
      longint acc, r;
      nb[DIR_WEST] = w;
      nb[DIR_EAST] = e;
      nb[DIR_SOUTH] = s;
      nb[DIR_NORTH] = n;
      acc = 0;
      for (int d = 0; d < NUM_DIRS; d++)
         acc += has[d] ? longint'(m_coeff) * (nb[d] - t) : side_term(d, t);
      r = t + ((acc + 32768) >>> 16);
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      return r[31:0];
   endfunction

   // Advance the mirror by one accepted word and queue the cells it releases
   task automatic predict_heat_step(input int t_in);
      int unsigned cols, rows, c, r;
      int self, east, west;
      int first;
      rsp_type emit;
      cols = m_cols < 2 ? 2 : (m_cols > NCOLS ? NCOLS : m_cols);
      rows = m_rows < 2 ? 2 : m_rows;
      c = m_col >= cols ? cols - 1 : m_col;
      r = m_row >= rows ? rows - 1 : m_row;
      first = pending_cells.size();
      if (r >= 1) begin
         self = m_middle[c];
         east = (c + 1 < cols) ? m_middle[c + 1] : 0;
         emit.new_temperature = next_temp(self, {1'b1, r >= 2, c + 1 < cols, c > 0},
                                          m_west, east, m_older[c], t_in);
         emit.col = COL_OUT_W'(c);
         emit.row = ROW_W'(r - 1);
         emit.last = 1'b0;
         pending_cells.push_back(emit);
         m_west = self;
         m_older[c] = self;
      end
      m_middle[c] = t_in;
      if (r + 1 == rows) begin
         if (c >= 1) begin
            west = (c >= 2) ? m_middle[c - 2] : 0;
            emit.new_temperature = next_temp(m_top, {1'b0, 1'b1, 1'b1, c >= 2},
                                             west, t_in, m_older[c - 1], 0);
            emit.col = COL_OUT_W'(c - 1);
            emit.row = ROW_W'(r);
            emit.last = 1'b0;
            pending_cells.push_back(emit);
         end
         if (c + 1 == cols) begin
            emit.new_temperature = next_temp(t_in, 4'b0101, m_middle[c - 1], 0,
                                             m_older[c], 0);
            emit.col = COL_OUT_W'(c);
            emit.row = ROW_W'(r);
            emit.last = 1'b0;
            pending_cells.push_back(emit);
         end
      end
      m_top = t_in;
      if (pending_cells.size() > first)
         pending_cells[pending_cells.size() - 1].last = 1'b1;
      c++;
      if (c >= cols) begin
         c = 0;
         r++;
         if (r >= rows) r = 0;
      end
      m_col = c;
      m_row = r;
   endtask

   // Register write: setup phase, access phase held until ready, then idle
   task automatic csr_write(input csr_reg_type idx, input logic [CSR_DW-1:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= CSR_AW'(idx) << CSR_IDX_LSB;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_GRID_COLS: begin
            m_cols = value[GCOLS_W-1:0];
            m_col = 0;
            m_row = 0;
         end
         REG_GRID_ROWS: begin
            m_rows = value[ROW_W-1:0];
            m_col = 0;
            m_row = 0;
         end
         REG_COEFF: m_coeff = value[COEFF_W-1:0];
         REG_SIDE_LEFT: m_side[DIR_WEST] = value[SIDE_W-1:0];
         REG_SIDE_RIGHT: m_side[DIR_EAST] = value[SIDE_W-1:0];
         REG_SIDE_BOT: m_side[DIR_SOUTH] = value[SIDE_W-1:0];
         REG_SIDE_TOP: m_side[DIR_NORTH] = value[SIDE_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Send one word, with a random gap first
   task automatic send_word(input int t);
      while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_temperature <= t;
      do @(posedge clock); while (req_stall);
      words_sent++;
      predict_heat_step(t);
   endtask

   // Drop valid, wait for every cell, then let the pipeline drain
   task automatic quiesce();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_cells.size() > 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   function automatic logic [CSR_DW-1:0] rand_side();
      return {14'd0, 18'($urandom_range(0, 18'h3ffff)), 32'($urandom)};
   endfunction

   function automatic int rand_temp();
      case ($urandom_range(0, 3))
         0: return int'($urandom);
         1: return int'($urandom_range(0, 2097152)) - 1048576;
         default: return int'($urandom_range(0, 65536 * 200)) - 65536 * 100;
      endcase
   endfunction

   // Receiver stall pattern
   always @(posedge clock)
      rsp_stall <= (stall_pct > 0) && ($urandom_range(0, 99) < stall_pct);

   // Compare each delivered cell with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_cells.size() == 0) begin
            report($sformatf("unexpected cell (%0d,%0d)", rsp_row, rsp_col));
         end else begin
            rsp_type e;
            e = pending_cells.pop_front();
            cells_checked++;
            if (rsp_new_temperature !== e.new_temperature)
               report($sformatf("cell (%0d,%0d) temperature %h, want %h", e.row, e.col,
                                rsp_new_temperature, e.new_temperature));
            if (rsp_col !== e.col)
               report($sformatf("col %0d, want %0d", rsp_col, e.col));
            if (rsp_row !== e.row)
               report($sformatf("row %0d, want %0d", rsp_row, e.row));
            if (rsp_last_of_run !== e.last)
               report($sformatf("cell (%0d,%0d) last_of_run %b, want %b", e.row, e.col,
                                rsp_last_of_run, e.last));
         end
      end
   end

   // Extreme values, clamped geometry, corners and grid wrap
   task automatic test_directed();
      int extremes [8] = '{32'h7fffffff, 32'h80000000, 0, -1, 1, 32'h00010000,
                           32'hffff0000, 32'h55555555};
      idle_pct = 0;
      stall_pct = 0;
      csr_write(REG_GRID_COLS, CSR_DW'(0));
      csr_write(REG_GRID_ROWS, CSR_DW'(1));
      csr_write(REG_COEFF, CSR_DW'(16'hffff));
      csr_write(REG_SIDE_LEFT, {14'd0, 18'h3ffff, 32'h7fffffff});
      csr_write(REG_SIDE_RIGHT, {14'd0, 18'h3ffff, 32'h80000000});
      csr_write(REG_SIDE_BOT, {14'd0, 18'h0, 32'h80000000});
      csr_write(REG_SIDE_TOP, {14'd0, 18'h10000, 32'h00010000});
      foreach (extremes[i]) send_word(extremes[i]);
      quiesce();
      csr_write(REG_GRID_COLS, CSR_DW'(3));
      csr_write(REG_GRID_ROWS, CSR_DW'(3));
      csr_write(REG_COEFF, CSR_DW'(0));
      for (int i = 0; i < 12; i++) send_word(extremes[7 - (i % 8)]);
      quiesce();
   endtask

   // Random settings and grids under one idling pattern
   task automatic test_random(input int idle, input int stall, input int n);
      idle_pct = idle;
      stall_pct = stall;
      for (int part = 0; part < 2; part++) begin
         csr_write(REG_GRID_COLS, CSR_DW'($urandom_range(2, 9)));
         csr_write(REG_GRID_ROWS, CSR_DW'($urandom_range(2, 6)));
         csr_write(REG_COEFF, CSR_DW'($urandom_range(0, 3) == 0 ? 32'hffff
                                                                 : $urandom_range(0, 16384)));
         csr_write(REG_SIDE_LEFT, rand_side());
         csr_write(REG_SIDE_RIGHT, rand_side());
         csr_write(REG_SIDE_BOT, rand_side());
         csr_write(REG_SIDE_TOP, rand_side());
         for (int i = 0; i < n / 2; i++) begin
            // hold off until the block has delivered everything
            if (part == 1 && i == n / 4) begin
               req_valid <= 1'b0;
               @(posedge clock);
               while (pending_cells.size() > 0) @(posedge clock);
            end
            send_word(rand_temp());
         end
         quiesce();
      end
   endtask

   // Widest grid and the tallest grid, each run partway
   task automatic test_wide_grid();
      idle_pct = 10;
      stall_pct = 10;
      csr_write(REG_GRID_COLS, CSR_DW'(11'h7ff));
      csr_write(REG_GRID_ROWS, CSR_DW'(2));
      csr_write(REG_COEFF, CSR_DW'($urandom_range(0, 65535)));
      for (int i = 0; i < 100; i++) send_word(rand_temp());
      quiesce();
      csr_write(REG_GRID_COLS, CSR_DW'(2));
      csr_write(REG_GRID_ROWS, CSR_DW'(16'hffff));
      for (int i = 0; i < 20; i++) send_word(rand_temp());
      quiesce();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(0, 0, 70);
      test_random(47, 0, 70);
      test_random(0, 47, 70);
      test_random(33, 33, 70);
      test_wide_grid();
      idle_pct = 0;
      stall_pct = 0;
      quiesce();
      $display("covered %0d words and %0d cells over clamped, small, widest and tallest grids",
               words_sent, cells_checked);
      if (errors == 0 && pending_cells.size() == 0) begin
         $display("PASS heat_stencil_step");
      end else begin
         $display("FAIL heat_stencil_step");
      end
      $finish;
   end

endmodule
